FILE: design/crl_pkg.sv
// ----------------------------------------------------------------------------
// crl_pkg: shared types and codes for the cursor ring list
// Command and status codes, plus the packed command and response words.
// ----------------------------------------------------------------------------
`default_nettype none

package crl_pkg;

	// Command codes
	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_POP    = 2'd1;
	localparam logic [1:0] CMD_ROTATE = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_RANGE = 2'd3;

	// Remainder unit works one dividend bit per cycle
	localparam int DIV_STEPS = 16;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [31:0]        item;
		logic signed [15:0] rotate_amount;
		logic [4:0]         read_offset;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] item_out;
		logic [5:0]  count;
	} rsp_word_t;

endpackage

`default_nettype wire

FILE: design/cursor_ring_list_top.sv
// ----------------------------------------------------------------------------
// cursor_ring_list_top: bounded ring of entries with a rotating cursor
// Timing: push, pop and read pass their result through S_PUT to the output
//   register; a rotate on a non-empty ring first takes 16 steps in S_DIV.
// Flow: one command at a time; cmd_stall holds the next off until the result
//   leaves S_PUT, which waits on rsp_stall; the 16-step remainder paces rotates.
// Reset (arst_n low): count and cursor clear, the ring is empty, no word out.
//   Entry storage is not cleared; only written entries are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_ring_list_top #(
	parameter int CAPACITY   = 32,
	parameter int ITEM_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire crl_pkg::cmd_word_t cmd_word,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output crl_pkg::rsp_word_t      rsp_word
);

	import crl_pkg::*;

	// Pointer width, count width (holds CAPACITY itself), index-sum width
	localparam int PW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = ((CW > 5) ? CW : 5) + 1;
	localparam int SW = $clog2(DIV_STEPS);

	// Sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_PUT  = 2'd2;

	logic [1:0]            state_q;
	logic [CW-1:0]         used_q;
	logic [PW-1:0]         cur_q;
	logic [SW-1:0]         cnt_q;

	// Result waiting to move into the output register
	logic [1:0]            res_status_q;
	logic [31:0]           res_item_q;

	// Remainder unit: dividend shift register, partial remainder, sign
	logic [DIV_STEPS-1:0]  div_q;
	logic [CW-1:0]         rem_q;
	logic                  neg_q;

	// Entry storage (shift line, one read port)
	logic [ITEM_WIDTH-1:0] ent_q [CAPACITY];

	logic                  acc;
	logic                  out_free;
	logic                  full;
	logic                  empty;
	logic                  push_en;
	logic                  pop_en;
	logic [ITEM_WIDTH-1:0] item_w;
	logic [IW-1:0]         rd_sum;
	logic [PW-1:0]         rd_addr;
	logic [ITEM_WIDTH-1:0] rd_data;
	logic                  range_bad;
	logic [CW-1:0]         used_dec;
	logic [PW-1:0]         pop_cur;
	logic [15:0]           ra_u;
	logic [15:0]           mag;
	logic [CW:0]           trial;
	logic [CW-1:0]         rem_nx;
	logic [CW:0]           cur_w;
	logic [CW:0]           step_w;
	logic [CW:0]           used_w;
	logic [CW:0]           rot_sum;
	logic [PW-1:0]         rot_cur;
	logic [1:0]            st_d;
	logic [31:0]           item_d;

	assign cmd_stall = (state_q != S_IDLE);
	assign acc       = cmd_valid && !cmd_stall;
	assign out_free  = !rsp_valid || !rsp_stall;

	assign full    = (used_q == CW'(CAPACITY));
	assign empty   = (used_q == '0);
	assign push_en = acc && (cmd_word.cmd == CMD_PUSH) && !full;
	assign pop_en  = acc && (cmd_word.cmd == CMD_POP) && !empty;
	assign item_w  = ITEM_WIDTH'(cmd_word.item);

	// Read port: the cursor for a pop, cursor plus offset (wrapped) for a read
	always_comb begin
		rd_sum = IW'(cur_q) + IW'(cmd_word.read_offset);
		if (rd_sum >= IW'(used_q)) begin
			rd_sum = rd_sum - IW'(used_q);
		end
		rd_addr = (cmd_word.cmd == CMD_POP) ? cur_q : rd_sum[PW-1:0];
	end

	assign rd_data   = ent_q[rd_addr];
	assign range_bad = (IW'(cmd_word.read_offset) >= IW'(used_q));

	// Pop: wrap the cursor once it reaches the new count
	assign used_dec = used_q - CW'(1);
	assign pop_cur  = (CW'(cur_q) >= used_dec) ? '0 : cur_q;

	// Magnitude of the signed rotate amount
	assign ra_u = cmd_word.rotate_amount;
	assign mag  = ra_u[15] ? (~ra_u + 16'd1) : ra_u;

	// One restoring remainder step per cycle
	always_comb begin
		trial = {rem_q, div_q[DIV_STEPS-1]};
		if (trial >= {1'b0, used_q}) begin
			rem_nx = CW'(trial - {1'b0, used_q});
		end else begin
			rem_nx = trial[CW-1:0];
		end
	end

	// Move the cursor by the final remainder
	always_comb begin
		cur_w  = (CW+1)'(cur_q);
		step_w = {1'b0, rem_nx};
		used_w = {1'b0, used_q};
		if (neg_q) begin
			if (cur_w >= step_w) begin
				rot_sum = cur_w - step_w;
			end else begin
				rot_sum = cur_w + used_w - step_w;
			end
		end else begin
			rot_sum = cur_w + step_w;
			if (rot_sum >= used_w) begin
				rot_sum = rot_sum - used_w;
			end
		end
		rot_cur = rot_sum[PW-1:0];
	end

	// Status and item of the response, worked out at acceptance
	always_comb begin
		st_d   = STAT_OK;
		item_d = '0;
		unique case (cmd_word.cmd)
			CMD_PUSH: begin
				if (full) begin
					st_d = STAT_FULL;
				end
			end
			CMD_POP: begin
				if (empty) begin
					st_d = STAT_EMPTY;
				end else begin
					item_d = 32'(rd_data);
				end
			end
			CMD_ROTATE: begin
				if (empty) begin
					st_d = STAT_EMPTY;
				end
			end
			CMD_READ: begin
				if (range_bad) begin
					st_d = STAT_RANGE;
				end else begin
					item_d = 32'(rd_data);
				end
			end
			default: begin
				st_d = STAT_OK;
			end
		endcase
	end

	// Sequencer and ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			used_q    <= '0;
			cur_q     <= '0;
			cnt_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_PUT;
						if (push_en) begin
							used_q <= used_q + CW'(1);
						end
						if (pop_en) begin
							used_q <= used_dec;
							cur_q  <= pop_cur;
						end
						if ((cmd_word.cmd == CMD_ROTATE) && !empty) begin
							state_q <= S_DIV;
							cnt_q   <= '0;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + SW'(1);
					if (cnt_q == SW'(DIV_STEPS - 1)) begin
						cur_q   <= rot_cur;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Output register: load from the pending result, drop once taken
			if ((state_q == S_PUT) && out_free) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			res_status_q <= st_d;
			res_item_q   <= item_d;
			div_q        <= mag;
			rem_q        <= '0;
			neg_q        <= ra_u[15];
		end else if (state_q == S_DIV) begin
			div_q <= {div_q[DIV_STEPS-2:0], 1'b0};
			rem_q <= rem_nx;
		end
		if ((state_q == S_PUT) && out_free) begin
			rsp_word.status   <= res_status_q;
			rsp_word.item_out <= res_item_q;
			rsp_word.count    <= 6'(used_q);
		end
	end

	// Entry shift line: push opens a slot at the cursor, pop closes it
	for (genvar g = 0; g < CAPACITY; g++) begin : g_ent
		always_ff @(posedge clk) begin
			if (push_en) begin
				if (PW'(g) == cur_q) begin
					ent_q[g] <= item_w;
				end else if (PW'(g) > cur_q) begin
					ent_q[g] <= ent_q[(g > 0) ? g - 1 : 0];
				end
			end else if (pop_en && (g < CAPACITY - 1)) begin
				if (PW'(g) >= cur_q) begin
					ent_q[g] <= ent_q[(g < CAPACITY - 1) ? g + 1 : g];
				end
			end
		end
	end

	// Cursor stays inside the filled part of the ring
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(cur_q) < used_q) || (used_q == '0 && cur_q == '0))
		else $error("cursor outside the filled entries");

	// Count never exceeds the ring size
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(CAPACITY))
		else $error("count above capacity");

	// Count changes only on an accepted command, and by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |->
			($past(acc) && ((used_q == $past(used_q) + CW'(1)) ||
			(used_q == $past(used_q) - CW'(1)))))
		else $error("count changed without a push or pop");

	// A new response word comes only out of the result hand-off state
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == S_PUT))
		else $error("response raised outside hand-off");

	// A rotate on a non-empty ring enters the remainder unit
	a_rotate_div: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd_word.cmd == CMD_ROTATE) && !empty) |=> (state_q == S_DIV))
		else $error("rotate skipped the remainder unit");

endmodule

`default_nettype wire

FILE: verif/crl_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crl_checker: response checker for the cursor ring list
// Keeps its own copy of the ring and cursor and updates it on every accepted
// command word. Compares each accepted response word with the oldest
// prediction and counts mismatches and stray words.
// ----------------------------------------------------------------------------
module crl_checker #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic               cmd_stall,
	input  crl_pkg::cmd_word_t cmd_word,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  crl_pkg::rsp_word_t rsp_word,
	output int                 mismatch_count,
	output int                 open_count
);

	import crl_pkg::*;

	logic [31:0] ring_entries [CAPACITY];
	int          fill_level  = 0;
	int          cursor_pos  = 0;
	int          error_total = 0;
	rsp_word_t   predicted_q [$];

	// Apply one command to the shadow ring and return the response it causes.
	function automatic rsp_word_t ring_apply(cmd_word_t w);
		rsp_word_t r;
		int        amt;
		int        step;
		int        idx;
		r.status   = STAT_OK;
		r.item_out = '0;
		case (w.cmd)
		CMD_PUSH: begin
			if (fill_level >= CAPACITY) begin
				r.status = STAT_FULL;
			end else begin
				for (int i = CAPACITY - 1; i > cursor_pos; i--)
					ring_entries[i] = ring_entries[i - 1];
				ring_entries[cursor_pos] = w.item;
				fill_level++;
			end
		end
		CMD_POP: begin
			if (fill_level == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				r.item_out = ring_entries[cursor_pos];
				for (int i = cursor_pos + 1; i < fill_level; i++)
					ring_entries[i - 1] = ring_entries[i];
				fill_level--;
				if (cursor_pos >= fill_level)
					cursor_pos = 0;
			end
		end
		CMD_ROTATE: begin
			if (fill_level == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				amt = $signed(w.rotate_amount);
				if (amt < 0) begin
					step = (-amt) % fill_level;
					cursor_pos = (cursor_pos >= step) ? cursor_pos - step
						: cursor_pos + fill_level - step;
				end else begin
					step = amt % fill_level;
					cursor_pos = cursor_pos + step;
					if (cursor_pos >= fill_level)
						cursor_pos = cursor_pos - fill_level;
				end
			end
		end
		default: begin
			if (int'(w.read_offset) >= fill_level) begin
				r.status = STAT_RANGE;
			end else begin
				idx = cursor_pos + int'(w.read_offset);
				if (idx >= fill_level)
					idx = idx - fill_level;
				r.item_out = ring_entries[idx];
			end
		end
		endcase
		r.count = 6'(fill_level);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t want;
		if (!arst_n) begin
			predicted_q.delete();
			fill_level  = 0;
			cursor_pos  = 0;
			error_total = 0;
		end else begin
			// Check the response first: it can never belong to a command
			// accepted at the same edge.
			if (rsp_valid && !rsp_stall) begin
				if (predicted_q.size() == 0) begin
					error_total++;
					if (error_total <= 10)
						$display("%0t: stray word: status %0d item %h count %0d",
							$time, rsp_word.status, rsp_word.item_out, rsp_word.count);
				end else begin
					want = predicted_q.pop_front();
					if (rsp_word.status !== want.status
							|| rsp_word.item_out !== want.item_out
							|| rsp_word.count !== want.count) begin
						error_total++;
						if (error_total <= 10) begin
							$display("%0t: mismatch, expected status %0d item %h count %0d",
								$time, want.status, want.item_out, want.count);
							$display("%0t: mismatch, actual   status %0d item %h count %0d",
								$time, rsp_word.status, rsp_word.item_out,
								rsp_word.count);
						end
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				predicted_q.push_back(ring_apply(cmd_word));
		end
		mismatch_count <= error_total;
		open_count     <= predicted_q.size();
	end

endmodule

FILE: verif/tb_cursor_ring_list_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cursor_ring_list_top: stimulus and verdict for the cursor ring list
// Runs a directed pass over the empty, wrap and range corners, then random
// phases that fill the ring to full, drain it to empty and mix operations,
// with bursty command traffic and a patterned response stall. A checker
// instance predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_cursor_ring_list_top;
	import crl_pkg::*;

	localparam int CAPACITY     = 32;
	localparam int ITEM_TARGET  = 1350;
	// Cycle budget for the whole run, with room for heavy stalls
	localparam int CYCLE_LIMIT  = 500000;
	// Longest command latency is a rotate; leave room past it
	localparam int QUIET_CYCLES = 40;

	// Shapes of the random stimulus
	typedef enum int {PH_FILL, PH_DRAIN, PH_MIX, PH_NOISE} phase_t;
	// Shapes of the response stall
	typedef enum int {RS_NONE, RS_LIGHT, RS_HEAVY, RS_COMB} stall_mode_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cmd_valid  = 1'b0;
	logic        cmd_stall;
	cmd_word_t   cmd_word   = '0;
	logic        rsp_valid;
	logic        rsp_stall  = 1'b0;
	rsp_word_t   rsp_word;

	int          mismatch_count;
	int          open_count;
	int          cycle_count = 0;

	// Rough fill level: only steers the stimulus, never checked
	int          level       = 0;
	int          items_sent  = 0;
	int          burst_left  = 0;
	bit          idle_on     = 1'b1;
	stall_mode_t stall_mode  = RS_NONE;
	int          stall_left  = 0;

	cursor_ring_list_top #(
		.CAPACITY  (CAPACITY),
		.ITEM_WIDTH(32)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word (cmd_word),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_word (rsp_word)
	);

	crl_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd_word      (cmd_word),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp_word      (rsp_word),
		.mismatch_count(mismatch_count),
		.open_count    (open_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop: a hung handshake or a lost response ends up here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Response stall: switch at random between no stall, sparse, dense and a
	// fixed comb, so stalls land on every phase of the work.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(50, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		RS_NONE:  rsp_stall <= 1'b0;
		RS_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
		RS_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
		default:  rsp_stall <= ((cycle_count % 7) < 3);
		endcase
	end

	// Present one command word and hold it until accepted. At the start of a
	// burst, drop valid for a random gap first when idling is on.
	task automatic offer_word(input cmd_word_t w);
		int gap;
		int pick;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = 0;
			if (idle_on) begin
				pick = $urandom_range(0, 9);
				if (pick >= 8)
					gap = $urandom_range(4, 12);
				else if (pick >= 3)
					gap = $urandom_range(1, 3);
			end
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		cmd_word  <= w;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		burst_left--;
		items_sent++;
		if (w.cmd == CMD_PUSH && level < CAPACITY)
			level++;
		else if (w.cmd == CMD_POP && level > 0)
			level--;
	endtask

	// Hold off the command side until every predicted word has come back.
	// Sample the count on the falling edge, away from the checker's update.
	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (open_count != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Random content for one command. Offsets mostly fall inside the ring;
	// rotate amounts mix small steps, raw 16-bit values, the two extremes and
	// near-multiples of the fill level.
	function automatic cmd_word_t rand_word(logic [1:0] op, bit wild);
		cmd_word_t w;
		w.cmd  = op;
		w.item = $urandom;
		case ($urandom_range(0, 3))
		0:       w.rotate_amount = 16'($urandom_range(0, 80) - 40);
		1:       w.rotate_amount = 16'($urandom);
		2:       w.rotate_amount = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
		default: begin
			w.rotate_amount = 16'(level * $urandom_range(0, 5) + $urandom_range(0, 2) - 1);
			if ($urandom_range(0, 1))
				w.rotate_amount = -w.rotate_amount;
		end
		endcase
		if (wild || level == 0 || $urandom_range(0, 4) == 0)
			w.read_offset = 5'($urandom_range(0, 31));
		else
			w.read_offset = 5'($urandom_range(0, level - 1));
		return w;
	endfunction

	initial begin
		phase_t     kind;
		logic [1:0] op;
		bit         first_phase;
		first_phase = 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pass: empty ring, refused pop, rotate on empty with the
		// most negative amount, then three entries at the value extremes.
		offer_word({CMD_READ,   32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_POP,    32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_ROTATE, 32'h0000_0000, 16'h8000, 5'd0});
		offer_word({CMD_PUSH,   32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_PUSH,   32'hFFFF_FFFF, 16'h0000, 5'd0});
		offer_word({CMD_PUSH,   32'h8000_0001, 16'h0000, 5'd0});
		// Reads inside, at the count and at the top offset
		offer_word({CMD_READ,   32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_READ,   32'h0000_0000, 16'h0000, 5'd2});
		offer_word({CMD_READ,   32'h0000_0000, 16'h0000, 5'd3});
		offer_word({CMD_READ,   32'h0000_0000, 16'h0000, 5'd31});
		// Rotate by the extremes and by one; this walks the cursor onto
		// the last entry
		offer_word({CMD_ROTATE, 32'h0000_0000, 16'h7FFF, 5'd0});
		offer_word({CMD_ROTATE, 32'h0000_0000, 16'hFFFF, 5'd0});
		offer_word({CMD_ROTATE, 32'h0000_0000, 16'h8000, 5'd0});
		offer_word({CMD_ROTATE, 32'h0000_0000, 16'h0001, 5'd0});
		// Read past the last entry wraps; pop at the end wraps the cursor
		offer_word({CMD_READ,   32'h0000_0000, 16'h0000, 5'd1});
		offer_word({CMD_POP,    32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_PUSH,   32'h5555_5555, 16'h0000, 5'd0});
		offer_word({CMD_PUSH,   32'hAAAA_AAAA, 16'h0000, 5'd0});
		offer_word({CMD_ROTATE, 32'h0000_0000, 16'h0000, 5'd0});
		// Drain to empty and poke the empty ring again
		offer_word({CMD_POP,    32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_POP,    32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_POP,    32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_POP,    32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_POP,    32'h0000_0000, 16'h0000, 5'd0});
		offer_word({CMD_READ,   32'h0000_0000, 16'h0000, 5'd0});

		// Let everything come back before the random part
		wait_idle();

		// Random phases; the first one always fills the ring to full so
		// refused pushes show up early.
		while (items_sent < ITEM_TARGET) begin
			kind        = first_phase ? PH_FILL : phase_t'($urandom_range(0, 3));
			idle_on     = ($urandom_range(0, 3) != 0);
			first_phase = 1'b0;
			case (kind)
			PH_FILL: begin
				while (level < CAPACITY) begin
					if ($urandom_range(0, 4) != 0)
						op = CMD_PUSH;
					else
						op = $urandom_range(0, 1) ? CMD_READ : CMD_ROTATE;
					offer_word(rand_word(op, 1'b0));
				end
				// Push into a full ring a few times
				repeat ($urandom_range(1, 3)) offer_word(rand_word(CMD_PUSH, 1'b0));
			end
			PH_DRAIN: begin
				while (level > 0) begin
					if ($urandom_range(0, 9) < 7)
						op = CMD_POP;
					else
						op = 2'($urandom_range(0, 3));
					offer_word(rand_word(op, 1'b0));
				end
				repeat ($urandom_range(1, 2)) offer_word(rand_word(CMD_POP, 1'b0));
			end
			PH_MIX: begin
				repeat ($urandom_range(20, 80))
					offer_word(rand_word(2'($urandom_range(0, 3)), 1'b0));
			end
			default: begin
				repeat ($urandom_range(5, 15))
					offer_word(rand_word(2'($urandom_range(0, 3)), 1'b1));
			end
			endcase
			if ($urandom_range(0, 3) == 0)
				wait_idle();
		end

		// Drain, then give the block time to show any stray word
		wait_idle();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
